// ----- hw/rtl/mse_pkg.sv -----
`default_nettype none

package mse_pkg;

    localparam int DATA_W = 32;

    // Sequencer states: take items, set up one pair of runs, merge it, read the result out.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEG,
        ST_MERGE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mse_ram.sv -----
`default_nettype none

module mse_ram
    import mse_pkg::*;
#(
    parameter int AW    = 6
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr_a,
    input  wire logic [AW-1:0]     raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    localparam int ROWS = 2 ** AW;

    logic [DATA_W-1:0] mem [ROWS];

    // One write port and two read ports. Read data is registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/merge_sort_engine.sv -----
`default_nettype none

// Channel   Handshake                      Payload
// ------    ---------------------------    -------------------------------
// input     start & !busy at clock edge    value_in[31:0] s, last_in
// result    result_valid, one cycle each   sorted_value[31:0] s, last_out
//
// Loading accepts one item per cycle while busy is low. An item with last_in
// set starts the sort: for n stored values it runs ceil(log2 n) merge passes,
// each with one priming step (ST_SEG) per pair of runs, then streams the n
// results, one per cycle. The registered read of the memories is why each
// pair of runs needs its priming step. Reset clears the count and control
// state; the memories are not cleared. Results cannot be stalled, so busy
// stays high until the final result has been shown.

module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] value_in,
    input  wire logic               last_in,
    output logic                    result_valid,
    output logic signed [31:0]      sorted_value,
    output logic                    last_out
);

    // AW indexes the memories, CW holds a count up to DEPTH, SW holds run-end sums.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;   // values stored in the current set
    logic [CW-1:0]   n_reg, n_next;           // size of the set being sorted
    logic [CW:0]     width_reg, width_next;   // run width of the current pass
    logic [CW-1:0]   lo_reg, lo_next;         // start of the current pair of runs
    logic [CW-1:0]   mid_reg, mid_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [CW-1:0]   a_reg, a_next;           // left run head, also the output index
    logic [CW-1:0]   b_reg, b_next;           // right run head
    logic [CW-1:0]   c_reg, c_next;           // write pointer into the destination
    logic            src_sel_reg, src_sel_next; // memory that holds the current runs
    logic            pend_reg, pend_next;
    logic            pend_last_reg, pend_last_next;

    logic [AW-1:0]     rd_addr_a, rd_addr_b;
    logic              we0, we1;
    logic [AW-1:0]     waddr0, waddr1;
    logic [DATA_W-1:0] wdata0, wdata1;
    logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic [DATA_W-1:0] src_a, src_b, merge_data;
    logic              take_a;
    logic [SW-1:0]     n_ext, lo_w_sum, lo_2w_sum, w2_ext;
    logic [CW-1:0]     mid_calc, hi_calc, n_calc;

    // Two ping-pong memories: each merge pass reads one and writes the other.
    mse_ram #(.AW(AW)) u_ram0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr0),
        .wdata   (wdata0),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    mse_ram #(.AW(AW)) u_ram1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr1),
        .wdata   (wdata1),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    // Heads of both runs, as read in the previous cycle.
    assign src_a = src_sel_reg ? rd1_a : rd0_a;
    assign src_b = src_sel_reg ? rd1_b : rd0_b;

    // Take the left head while it lasts and is not above the right head; on a tie
    // the earlier run goes first.
    assign take_a = (a_reg < mid_reg)
                 && ((b_reg >= hi_reg) || ($signed(src_a) <= $signed(src_b)));
    assign merge_data = take_a ? src_a : src_b;

    // Run bounds, clipped to the set size.
    assign n_ext     = SW'(n_reg);
    assign w2_ext    = SW'(width_reg) << 1;
    assign lo_w_sum  = SW'(lo_reg) + SW'(width_reg);
    assign lo_2w_sum = SW'(lo_reg) + w2_ext;
    assign mid_calc  = (lo_w_sum < n_ext) ? lo_w_sum[CW-1:0] : n_reg;
    assign hi_calc   = (lo_2w_sum < n_ext) ? lo_2w_sum[CW-1:0] : n_reg;
    assign n_calc    = (count_reg < CW'(DEPTH)) ? count_reg + CW'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            width_reg     <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            src_sel_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            src_sel_reg   <= src_sel_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        src_sel_next   = src_sel_reg;
        pend_next      = 1'b0;
        pend_last_next = 1'b0;
        rd_addr_a      = a_reg[AW-1:0];
        rd_addr_b      = b_reg[AW-1:0];
        we0            = 1'b0;
        we1            = 1'b0;
        waddr0         = count_reg[AW-1:0];
        waddr1         = c_reg[AW-1:0];
        wdata0         = value_in;
        wdata1         = merge_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take nothing while the final result of the last set is still shown.
                if (start && !busy)
                begin
                    // Store the item while there is room; drop it silently when full.
                    if (count_reg < CW'(DEPTH))
                    begin
                        we0        = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (last_in)
                    begin
                        n_next       = n_calc;
                        count_next   = '0;
                        width_next   = (CW + 1)'(1);
                        lo_next      = '0;
                        a_next       = '0;
                        src_sel_next = 1'b0;
                        // A set of one value is already sorted.
                        state_next   = (n_calc == CW'(1)) ? ST_OUT : ST_SEG;
                    end
                end
            end

            ST_SEG:
            begin
                // Prime the heads of both runs.
                a_next     = lo_reg;
                b_next     = mid_calc;
                c_next     = lo_reg;
                mid_next   = mid_calc;
                hi_next    = hi_calc;
                rd_addr_a  = lo_reg[AW-1:0];
                rd_addr_b  = mid_calc[AW-1:0];
                state_next = ST_MERGE;
            end

            ST_MERGE:
            begin
                // Write one merged value, advance the chosen head and fetch it again.
                we0 = src_sel_reg;
                we1 = !src_sel_reg;
                waddr0 = c_reg[AW-1:0];
                wdata0 = merge_data;
                if (take_a)
                begin
                    a_next = a_reg + CW'(1);
                end
                else
                begin
                    b_next = b_reg + CW'(1);
                end
                rd_addr_a = a_next[AW-1:0];
                rd_addr_b = b_next[AW-1:0];
                c_next    = c_reg + CW'(1);
                if (c_next == hi_reg)
                begin
                    if (lo_2w_sum >= n_ext)
                    begin
                        // Pass done: swap memories and double the run width.
                        src_sel_next = !src_sel_reg;
                        width_next   = w2_ext[CW:0];
                        lo_next      = '0;
                        if (w2_ext >= n_ext)
                        begin
                            a_next     = '0;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_SEG;
                        end
                    end
                    else
                    begin
                        lo_next    = lo_2w_sum[CW-1:0];
                        state_next = ST_SEG;
                    end
                end
            end

            ST_OUT:
            begin
                // Read one sorted value per cycle; it shows up on the next cycle.
                rd_addr_a      = a_reg[AW-1:0];
                pend_next      = 1'b1;
                pend_last_next = (a_reg + CW'(1) == n_reg);
                a_next         = a_reg + CW'(1);
                if (pend_last_next)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold off new items until the final result has left.
    assign busy         = (state_reg != ST_IDLE) || pend_reg;
    assign result_valid = pend_reg;
    assign sorted_value = $signed(src_a);
    assign last_out     = pend_reg && pend_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stored count exceeds capacity");

    a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (c_reg < hi_reg) && (a_reg <= mid_reg)
                                    && (b_reg <= hi_reg))
        else $error("merge pointer out of its run");

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result shown while not busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_out) |=> !busy && !result_valid)
        else $error("block still busy after final result");

    a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (a_reg < n_reg))
        else $error("output index beyond set size");

endmodule

`default_nettype wire

// ----- tb/sv/tb_merge_sort_engine.sv -----
`default_nettype none

module tb_merge_sort_engine;
    import mse_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int TARGET_ITEMS = 420;
    localparam int CYCLE_LIMIT = 200000;
    localparam int GAP_PCT = 16;
    // Window of items sent with no idle cycles at all.
    localparam int CALM_FROM = 200;
    localparam int CALM_TO = 300;
    localparam int REPORT_MAX = 10;
    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

    // One value offered to the sorter, and one value it hands back.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } word_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [DATA_W-1:0] value_in = '0;
    logic                     last_in = 1'b0;
    logic                     result_valid;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;

    // Values still to offer, and sorted values the block still owes us.
    word_t                    values_to_send[$];
    word_t                    sorted_due[$];
    word_t                    got_word;

    // Shadow copy of the block's store and fill count.
    logic signed [DATA_W-1:0] held_vals[STORE_DEPTH];
    int                       held_count = 0;

    logic                     item_taken = 1'b0;
    int                       sent_count = 0;
    int                       error_count = 0;
    int                       cycle_count = 0;

    merge_sort_engine #(
        .DEPTH (STORE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value_in     (value_in),
        .last_in      (last_in),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .last_out     (last_out)
    );

    always #5 clk = ~clk;

    // Store one accepted value; on the closing item sort what is held and
    // queue the whole ascending run, flagging its final entry.
    task automatic absorb_value(input logic signed [DATA_W-1:0] v, input logic closes);
        logic signed [DATA_W-1:0] run[STORE_DEPTH];
        logic signed [DATA_W-1:0] key;
        word_t                    w;
        int                       i;
        int                       j;
        // Drop the value silently once the store is full.
        if (held_count < STORE_DEPTH) begin
            held_vals[held_count] = v;
            held_count++;
        end
        if (closes) begin
            for (i = 0; i < held_count; i++) begin
                run[i] = held_vals[i];
            end
            // Insertion sort, signed compare; ties keep arrival order.
            for (i = 1; i < held_count; i++) begin
                key = run[i];
                j = i - 1;
                while (j >= 0 && run[j] > key) begin
                    run[j + 1] = run[j];
                    j--;
                end
                run[j + 1] = key;
            end
            for (i = 0; i < held_count; i++) begin
                w.value = run[i];
                w.last = (i == held_count - 1);
                sorted_due.push_back(w);
            end
            held_count = 0;
        end
    endtask

    // Mostly full-range values, some extremes, some from a tiny range so
    // that equal values are common.
    function automatic logic signed [DATA_W-1:0] pick_value(input bit narrow);
        int mode;
        mode = $urandom_range(9);
        if (narrow || mode < 2) begin
            return $signed($urandom_range(6)) - 3;
        end
        if (mode == 2) begin
            return ($urandom_range(1) != 0) ? MOST_NEG : MOST_POS;
        end
        return $signed($urandom());
    endfunction

    task automatic queue_value(input logic signed [DATA_W-1:0] v, input logic closes);
        word_t w;
        w.value = v;
        w.last = closes;
        values_to_send.push_back(w);
    endtask

    // Queue a set of n values; only the final one closes the set.
    task automatic queue_set(input int n, input bit narrow);
        int k;
        for (k = 0; k < n; k++) begin
            queue_value(pick_value(narrow), k == n - 1);
        end
    endtask

    // Driver: present items at the falling edge. Hold an item that has not
    // been taken yet; otherwise advance to the next one or idle at random.
    always @(negedge clk) begin
        if (rst_n) begin
            if (start && item_taken) begin
                void'(values_to_send.pop_front());
                sent_count++;
            end
            if (!(start && !item_taken)) begin
                if (values_to_send.size() != 0 &&
                    ($urandom_range(99) >= GAP_PCT ||
                     (sent_count >= CALM_FROM && sent_count < CALM_TO))) begin
                    start <= 1'b1;
                    value_in <= values_to_send[0].value;
                    last_in <= values_to_send[0].last;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: at the rising edge note whether an item went in and check any
    // result shown against the oldest value still owed.
    always @(posedge clk) begin
        if (!rst_n) begin
            item_taken <= 1'b0;
        end
        else begin
            item_taken <= start && !busy;
            if (start && !busy) begin
                absorb_value(value_in, last_in);
            end
            if (result_valid) begin
                if (sorted_due.size() == 0) begin
                    if (error_count < REPORT_MAX) begin
                        $display("unexpected result: value %0d last %0b",
                                 sorted_value, last_out);
                    end
                    error_count++;
                end
                else begin
                    got_word = sorted_due.pop_front();
                    if (sorted_value !== got_word.value || last_out !== got_word.last) begin
                        if (error_count < REPORT_MAX) begin
                            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                                     got_word.value, got_word.last, sorted_value, last_out);
                        end
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a stuck block ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        // Directed sets: a lone value, then the field extremes mixed with
        // zero and its neighbors.
        queue_value(MOST_NEG, 1'b1);
        queue_value(MOST_POS, 1'b0);
        queue_value(MOST_NEG, 1'b0);
        queue_value(0, 1'b0);
        queue_value(-1, 1'b0);
        queue_value(1, 1'b0);
        queue_value(MOST_POS, 1'b1);
        // Equal values across runs.
        queue_value(5, 1'b0);
        queue_value(5, 1'b0);
        queue_value(-5, 1'b0);
        queue_value(5, 1'b1);
        // Two values already in descending order.
        queue_value(7, 1'b0);
        queue_value(-7, 1'b1);
        // Odd-sized set so the last run is short.
        queue_value(3, 1'b0);
        queue_value(2, 1'b0);
        queue_value(1, 1'b1);

        // Full store, then one extra value carrying the last flag (dropped,
        // sort still runs), then a set that overruns by three.
        queue_set(STORE_DEPTH, 1'b0);
        queue_set(STORE_DEPTH + 1, 1'b0);
        queue_set(STORE_DEPTH + 3, 1'b1);

        // Random sets: mostly small, now and then near or past capacity.
        while (values_to_send.size() < TARGET_ITEMS) begin
            if ($urandom_range(99) < 5) begin
                queue_set($urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6), 1'b0);
            end
            else begin
                queue_set($urandom_range(1, 12), $urandom_range(3) == 0);
            end
        end

        // Hold reset, then release it away from the rising edge.
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: wait until every item went in and every result came out,
        // then give the block a margin to show anything spurious.
        while (values_to_send.size() != 0 || sorted_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end
        else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
